/* rtl/dhcp_option_parser_macros.svh */
// Assertion macros shared by the DHCP option parser RTL.
`ifndef DHCP_OPTION_PARSER_MACROS_SVH
`define DHCP_OPTION_PARSER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define DOP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define DOP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dhcpop_pkg.sv */
// Types, option codes and constants for the DHCP option parser.
`default_nettype none

package dhcpop_pkg;

    // Fixed header length and default packet size used for the size fallback
    localparam int unsigned HEADER_BYTES = 240;
    localparam int unsigned PACKET_BYTES = 576;

    // Option codes
    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_END       = 8'd255;
    localparam logic [7:0] OPT_REQ_ADDR  = 8'd50;
    localparam logic [7:0] OPT_LEASE     = 8'd51;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_PARAM_REQ = 8'd55;
    localparam logic [7:0] OPT_MAX_SIZE  = 8'd57;
    localparam logic [7:0] OPT_REBIND    = 8'd59;
    localparam logic [7:0] OPT_SUBNET    = 8'd118;

    // Kept-field slots
    localparam int unsigned FIELD_COUNT = 7;
    localparam logic [2:0] FLD_TYPE   = 3'd0;
    localparam logic [2:0] FLD_SERVER = 3'd1;
    localparam logic [2:0] FLD_LEASE  = 3'd2;
    localparam logic [2:0] FLD_SIZE   = 3'd3;
    localparam logic [2:0] FLD_REQ    = 3'd4;
    localparam logic [2:0] FLD_REBIND = 3'd5;
    localparam logic [2:0] FLD_SUBNET = 3'd6;
    localparam logic [2:0] FLD_NONE   = 3'd7;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_SERVER_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEASE      = 1'b1;
    localparam logic [31:0] MAX_LEASE_RESET = 32'd86400;

    // Walk phase of the option record parser
    typedef enum logic [1:0] {
        PH_CODE,
        PH_LEN,
        PH_VALUE
    } t_phase;

    // What the back end does with one item
    typedef enum logic [1:0] {
        OP_NONE,
        OP_CLEAR,
        OP_BYTE,
        OP_PARAM
    } t_op_kind;

    // Classified item passed from the walker to the collector
    typedef struct packed {
        logic       cnt;     // counts toward the area byte count
        t_op_kind   kind;
        logic [2:0] fld;
        logic [1:0] pos;     // value byte position, 0 is most significant
        logic [7:0] data;
        logic       emit;    // a summary result leaves with this item
        logic       ended;   // result was caused by the END option
        logic       last;    // final byte of the packet
    } t_op;

    // Walker status
    typedef struct packed {
        t_phase phase;
        logic   done;
    } t_front_status;

    // One summary result
    typedef struct packed {
        logic [7:0]  message_type;
        logic [31:0] server_id;
        logic [31:0] lease_seconds;
        logic [15:0] max_message_size;
        logic [31:0] requested_address;
        logic [31:0] rebind_seconds;
        logic [31:0] subnet_address;
        logic [63:0] params_0_63;
        logic [63:0] params_64_127;
        logic [63:0] params_128_191;
        logic [63:0] params_192_255;
        logic        ended_by_end_option;
    } t_result;

    // Option code to kept-field slot
    function automatic logic [2:0] field_of(input logic [7:0] code);
        logic [2:0] f;
        unique case (code)
            OPT_MSG_TYPE:  f = FLD_TYPE;
            OPT_SERVER_ID: f = FLD_SERVER;
            OPT_LEASE:     f = FLD_LEASE;
            OPT_MAX_SIZE:  f = FLD_SIZE;
            OPT_REQ_ADDR:  f = FLD_REQ;
            OPT_REBIND:    f = FLD_REBIND;
            OPT_SUBNET:    f = FLD_SUBNET;
            default:       f = FLD_NONE;
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

/* rtl/dhcpop_fifo.sv */
// Small register FIFO used between the parser stages and at the result side.
`default_nettype none

module dhcpop_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             s_push_ok;
    logic             s_pop_ok;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign s_push_ok = i_push && !o_full;
    assign s_pop_ok  = i_pop && !o_empty;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (s_push_ok && !s_pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!s_push_ok && s_pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (s_push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (s_pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    // storage, no reset
    always_ff @(posedge i_clk) begin
        if (s_push_ok) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/dhcpop_front.sv */
// Option walker: tracks code/length/value records and classifies each item.
`default_nettype none

module dhcpop_front (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_accept,
    input  wire logic [7:0]             i_option_byte,
    input  wire logic                   i_last_byte,
    output dhcpop_pkg::t_op             o_op,
    output dhcpop_pkg::t_front_status   o_status
);

    import dhcpop_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_code, n_code;
    logic [7:0] r_left, n_left;
    logic [2:0] r_pos, n_pos;
    logic       r_done, n_done;
    logic [2:0] s_fld_byte;
    logic [2:0] s_fld_code;

    assign s_fld_byte = field_of(i_option_byte);
    assign s_fld_code = field_of(r_code);

    assign o_status.phase = r_phase;
    assign o_status.done  = r_done;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CODE;
            r_code  <= '0;
            r_left  <= '0;
            r_pos   <= '0;
            r_done  <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_code  <= n_code;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_done  <= n_done;
        end
    end

    // next state and item classification
    always_comb begin
        n_phase = r_phase;
        n_code  = r_code;
        n_left  = r_left;
        n_pos   = r_pos;
        n_done  = r_done;

        o_op       = '0;
        o_op.kind  = OP_NONE;
        o_op.fld   = FLD_NONE;
        o_op.data  = i_option_byte;
        o_op.cnt   = !r_done;
        o_op.last  = i_last_byte;

        if (!r_done) begin
            unique case (r_phase)
                PH_CODE: begin
                    if (i_option_byte == OPT_END) begin
                        o_op.emit  = 1'b1;
                        o_op.ended = 1'b1;
                        n_done     = 1'b1;
                    end else if (i_option_byte != OPT_PAD) begin
                        n_code  = i_option_byte;
                        n_phase = PH_LEN;
                        if (s_fld_byte != FLD_NONE) begin
                            o_op.kind = OP_CLEAR;
                            o_op.fld  = s_fld_byte;
                        end
                    end
                end
                PH_LEN: begin
                    n_left  = i_option_byte;
                    n_pos   = '0;
                    n_phase = (i_option_byte != 8'd0) ? PH_VALUE : PH_CODE;
                end
                PH_VALUE: begin
                    if (r_code == OPT_PARAM_REQ) begin
                        o_op.kind = OP_PARAM;
                    end else if (s_fld_code != FLD_NONE && !r_pos[2]) begin
                        o_op.kind = OP_BYTE;
                        o_op.fld  = s_fld_code;
                        o_op.pos  = r_pos[1:0];
                        n_pos     = r_pos + 3'd1;
                    end
                    n_left = r_left - 8'd1;
                    if (r_left == 8'd1) begin
                        n_phase = PH_CODE;
                    end
                end
                default: begin
                    n_phase = PH_CODE;
                end
            endcase

            // area ran out without END
            if (i_last_byte && !o_op.emit) begin
                o_op.emit  = 1'b1;
                o_op.ended = 1'b0;
            end
        end

        // packet boundary: walker returns to its reset state
        if (i_last_byte) begin
            n_phase = PH_CODE;
            n_code  = '0;
            n_left  = '0;
            n_pos   = '0;
            n_done  = 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/dhcpop_back.sv */
// Collector: applies classified items to the kept fields and forms the summary.
`default_nettype none

module dhcpop_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dhcpop_pkg::t_op     i_op,
    input  wire logic                i_op_valid,
    output logic                     o_op_pop,
    input  wire logic                i_res_full,
    output logic                     o_res_push,
    output dhcpop_pkg::t_result      o_res,
    input  wire logic [31:0]         i_server_address,
    input  wire logic [31:0]         i_max_lease
);

    import dhcpop_pkg::*;

    logic [31:0]       r_fields [FIELD_COUNT];
    logic [31:0]       n_fields [FIELD_COUNT];
    logic [3:0][63:0]  r_params, n_params;
    logic [15:0]       r_count, n_count;
    logic [4:0]        s_shift;
    logic [16:0]       s_hdr_sum;
    logic [15:0]       s_size_raw;
    logic [15:0]       s_size_dflt;
    logic [31:0]       s_lease_raw;
    logic [31:0]       s_subnet_raw;

    // handshake: an emitting item waits for room in the result queue
    assign o_op_pop   = i_op_valid && (!i_op.emit || !i_res_full);
    assign o_res_push = i_op_valid && i_op.emit && !i_res_full;

    // value byte lands at bits 31-8*pos
    assign s_shift = {~i_op.pos, 3'b000};

    // field, map and byte count updates for the head item
    always_comb begin
        n_fields = r_fields;
        n_params = r_params;
        n_count  = r_count;
        if (i_op.cnt && r_count != 16'hFFFF) begin
            n_count = r_count + 16'd1;
        end
        case (i_op.kind)
            OP_CLEAR: begin
                if (i_op.fld != FLD_NONE) begin
                    n_fields[i_op.fld] = '0;
                end
            end
            OP_BYTE: begin
                if (i_op.fld != FLD_NONE) begin
                    n_fields[i_op.fld] = r_fields[i_op.fld] | ({24'd0, i_op.data} << s_shift);
                end
            end
            OP_PARAM: begin
                n_params[i_op.data[7:6]][i_op.data[5:0]] = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // summary with defaults and lease clamp
    assign s_hdr_sum    = 17'(HEADER_BYTES) + {1'b0, n_count};
    assign s_size_raw   = n_fields[FLD_SIZE][31:16];
    assign s_lease_raw  = n_fields[FLD_LEASE];
    assign s_subnet_raw = n_fields[FLD_SUBNET];

    always_comb begin
        if (n_fields[FLD_TYPE][31:24] == 8'd0) begin
            s_size_dflt = s_hdr_sum[16] ? 16'hFFFF : s_hdr_sum[15:0];
        end else begin
            s_size_dflt = 16'(PACKET_BYTES);
        end
    end

    always_comb begin
        o_res.message_type      = n_fields[FLD_TYPE][31:24];
        o_res.server_id         = n_fields[FLD_SERVER];
        o_res.lease_seconds     = (s_lease_raw == 32'd0 || s_lease_raw > i_max_lease)
                                  ? i_max_lease : s_lease_raw;
        o_res.max_message_size  = (s_size_raw == 16'd0) ? s_size_dflt : s_size_raw;
        o_res.requested_address = n_fields[FLD_REQ];
        o_res.rebind_seconds    = n_fields[FLD_REBIND];
        o_res.subnet_address    = (s_subnet_raw == 32'd0) ? i_server_address : s_subnet_raw;
        o_res.params_0_63       = n_params[0];
        o_res.params_64_127     = n_params[1];
        o_res.params_128_191    = n_params[2];
        o_res.params_192_255    = n_params[3];
        o_res.ended_by_end_option = i_op.ended;
    end

    // packet state; cleared at reset and after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
                r_fields[i] <= '0;
            end
            r_params <= '0;
            r_count  <= '0;
        end else if (o_op_pop) begin
            if (i_op.last) begin
                for (int i = 0; i < FIELD_COUNT; i++) begin
                    r_fields[i] <= '0;
                end
                r_params <= '0;
                r_count  <= '0;
            end else begin
                r_fields <= n_fields;
                r_params <= n_params;
                r_count  <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/dhcp_option_parser.sv */
// DHCP option area parser, top level.
//
// Usage: option-area bytes enter on the push/full side, one item per byte,
// with i_last_byte marking the final byte of the received packet. A byte is
// taken at any clock edge with i_push high and o_full low. At the END option,
// or at the last byte when END was not seen, one summary item appears on the
// result side: it is valid while o_empty is low and leaves at an edge with
// i_pop high. Bytes after END are dropped until the last byte.
// Unless stalled, throughput is one byte per cycle; walker and collector each
// handle one item per cycle. A result passes through the item queue and then
// the result queue before o_empty goes low. If the receiver stalls, results
// pile up in the result queue, then the collector holds, the item queue fills
// and o_full rises. Configuration writes (server address, maximum lease) take
// effect at once; the user must make them only while no packet is in flight,
// which the block does not enforce. Reset is synchronous, active low: both
// queues empty, the packet state clears, the maximum lease returns to 86400
// and the server address to zero. Reset needs no clearing pass.
`default_nettype none

`include "dhcp_option_parser_macros.svh"

module dhcp_option_parser #(
    parameter int unsigned OP_QUEUE_DEPTH     = 2,
    parameter int unsigned RESULT_QUEUE_DEPTH = 2
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // byte input
    input  wire logic                                i_push,
    output logic                                     o_full,
    input  wire logic [7:0]                          i_option_byte,
    input  wire logic                                i_last_byte,
    // result output
    output logic                                     o_empty,
    input  wire logic                                i_pop,
    output logic [7:0]                               o_message_type,
    output logic [31:0]                              o_server_id,
    output logic [31:0]                              o_lease_seconds,
    output logic [15:0]                              o_max_message_size,
    output logic [31:0]                              o_requested_address,
    output logic [31:0]                              o_rebind_seconds,
    output logic [31:0]                              o_subnet_address,
    output logic [63:0]                              o_params_0_63,
    output logic [63:0]                              o_params_64_127,
    output logic [63:0]                              o_params_128_191,
    output logic [63:0]                              o_params_192_255,
    output logic                                     o_ended_by_end_option,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [dhcpop_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [dhcpop_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import dhcpop_pkg::*;

    localparam int unsigned OP_W  = $bits(t_op);
    localparam int unsigned RES_W = $bits(t_result);

    logic [31:0]      r_server_address;
    logic [31:0]      r_max_lease;

    logic             s_in_accept;
    t_op              s_op_in;
    t_op              s_op_head;
    logic [OP_W-1:0]  s_op_rdata;
    logic             s_op_empty;
    logic             s_op_pop;
    t_front_status    s_front_st;

    t_result          s_res_in;
    t_result          s_res_head;
    logic [RES_W-1:0] s_res_rdata;
    logic             s_res_push;
    logic             s_res_full;

    logic             s_rearmed;
    logic             s_lease_ok;

    assign s_in_accept = i_push && !o_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_server_address <= '0;
            r_max_lease      <= MAX_LEASE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SERVER_ADDRESS: r_server_address <= i_cfg_data;
                CFG_MAX_LEASE:      r_max_lease      <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // walker
    dhcpop_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (s_in_accept),
        .i_option_byte (i_option_byte),
        .i_last_byte   (i_last_byte),
        .o_op          (s_op_in),
        .o_status      (s_front_st)
    );

    // item queue between walker and collector
    dhcpop_fifo #(
        .WIDTH (OP_W),
        .DEPTH (OP_QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_in_accept),
        .i_data  (s_op_in),
        .o_full  (o_full),
        .i_pop   (s_op_pop),
        .o_data  (s_op_rdata),
        .o_empty (s_op_empty)
    );

    assign s_op_head = t_op'(s_op_rdata);

    // collector
    dhcpop_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (s_op_head),
        .i_op_valid       (!s_op_empty),
        .o_op_pop         (s_op_pop),
        .i_res_full       (s_res_full),
        .o_res_push       (s_res_push),
        .o_res            (s_res_in),
        .i_server_address (r_server_address),
        .i_max_lease      (r_max_lease)
    );

    // result queue
    dhcpop_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_res_push),
        .i_data  (s_res_in),
        .o_full  (s_res_full),
        .i_pop   (i_pop),
        .o_data  (s_res_rdata),
        .o_empty (o_empty)
    );

    assign s_res_head = t_result'(s_res_rdata);

    assign o_message_type        = s_res_head.message_type;
    assign o_server_id           = s_res_head.server_id;
    assign o_lease_seconds       = s_res_head.lease_seconds;
    assign o_max_message_size    = s_res_head.max_message_size;
    assign o_requested_address   = s_res_head.requested_address;
    assign o_rebind_seconds      = s_res_head.rebind_seconds;
    assign o_subnet_address      = s_res_head.subnet_address;
    assign o_params_0_63         = s_res_head.params_0_63;
    assign o_params_64_127       = s_res_head.params_64_127;
    assign o_params_128_191      = s_res_head.params_128_191;
    assign o_params_192_255      = s_res_head.params_192_255;
    assign o_ended_by_end_option = s_res_head.ended_by_end_option;

    // checks
    assign s_rearmed  = (s_front_st.phase == PH_CODE) && !s_front_st.done;
    assign s_lease_ok = (o_lease_seconds <= r_max_lease)
                        && (o_lease_seconds != 32'd0 || r_max_lease == 32'd0);

    `DOP_ASSERT_NEXT(a_walker_rearms, s_in_accept && i_last_byte, s_rearmed, "walker not rearmed")
    `DOP_ASSERT_SAME(a_lease_clamped, !o_empty, s_lease_ok, "lease result outside clamp")
    `DOP_ASSERT_SAME(a_size_nonzero, !o_empty, o_max_message_size != 16'd0, "zero size result")

endmodule

`default_nettype wire
